// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker ohc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset.
`define OHC_ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Implication: when cond holds, expr holds in the same cycle.
`define OHC_ASSERT_IMPLY(lbl, clk, rstn, cond, expr) \
	`OHC_ASSERT_CLK(lbl, clk, rstn, (cond) |-> (expr))

`endif

// ===== hw/rtl/ohc_pkg.sv =====
// Types, constants and helper functions of the odometry heading block.
// No dependencies.
package ohc_pkg;

	localparam int CIRC_W  = 24;
	localparam int PPR_W   = 16;
	localparam int BASE_W  = 24;
	localparam int CNT_W   = 32;
	localparam int MAG_W   = 55;
	localparam int DIFF_W  = 57;
	localparam int DMAG_W  = 56;
	localparam int MODV_W  = 55;
	localparam int THETA_W = 31;
	localparam int VEC_W   = 32;
	localparam int IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [30:0] Q28_TWO_PI  = 31'd1686629713;
	localparam logic [30:0] Q28_PI      = 31'd843314857;
	localparam logic [30:0] Q28_HALF_PI = 31'd421657428;
	localparam logic signed [VEC_W-1:0] CORDIC_START = 32'sd39796928;

	localparam logic [IDX_W-1:0] REG_CIRC = 2'd0;
	localparam logic [IDX_W-1:0] REG_PPR  = 2'd1;
	localparam logic [IDX_W-1:0] REG_BASE = 2'd2;

	localparam logic [31:0] ATAN_TAB [0:10] = '{
		32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
		32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287, 32'd262144
	};

	typedef struct packed {
		logic signed [CNT_W-1:0] left_count;
		logic signed [CNT_W-1:0] right_count;
	} counts_t;

	typedef struct packed {
		logic [7:0] x_msb;
		logic [7:0] x_lsb;
		logic [7:0] z_msb;
		logic [7:0] z_lsb;
		logic [7:0] y_msb;
		logic [7:0] y_lsb;
	} regs_t;

	typedef struct packed {
		logic             neg_l;
		logic [MAG_W-1:0] mag_l;
		logic             neg_r;
		logic [MAG_W-1:0] mag_r;
	} arc_item_t;

	function automatic logic signed [VEC_W-1:0] atan_q28(input int unsigned i);
		logic [31:0] v;
		v = 32'd0;
		if (i < 11) begin
			v = ATAN_TAB[i];
		end else if (i <= 28) begin
			v = 32'd1 << (28 - i);
		end
		return signed'(v);
	endfunction

endpackage

// ===== hw/rtl/ohc_front.sv =====
// Input stage: takes count pairs and forms sign and magnitude of count times circumference.
// Depends on ohc_pkg.
module ohc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    counts_valid,
	output logic                    counts_stall,
	input  ohc_pkg::counts_t        counts,
	input  logic [ohc_pkg::CIRC_W-1:0] circ,
	input  logic                    full,
	output logic                    push,
	output ohc_pkg::arc_item_t      push_data
);
	import ohc_pkg::*;

	counts_t         front_q;
	logic            front_valid_q;
	logic [CNT_W-1:0] mag_l, mag_r;
	logic [CNT_W+CIRC_W-1:0] prod_l, prod_r;
	logic            accept;

	assign push         = front_valid_q && !full;
	assign counts_stall = front_valid_q && full;
	assign accept       = counts_valid && !counts_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (accept) begin
			front_valid_q <= 1'b1;
		end else if (push) begin
			front_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= counts;
		end
	end

	assign mag_l  = front_q.left_count[CNT_W-1] ? CNT_W'(-front_q.left_count) :
		CNT_W'(front_q.left_count);
	assign mag_r  = front_q.right_count[CNT_W-1] ? CNT_W'(-front_q.right_count) :
		CNT_W'(front_q.right_count);
	assign prod_l = {{CIRC_W{1'b0}}, mag_l} * {{CNT_W{1'b0}}, circ};
	assign prod_r = {{CIRC_W{1'b0}}, mag_r} * {{CNT_W{1'b0}}, circ};

	assign push_data.neg_l = front_q.left_count[CNT_W-1];
	assign push_data.mag_l = prod_l[MAG_W-1:0];
	assign push_data.neg_r = front_q.right_count[CNT_W-1];
	assign push_data.mag_r = prod_r[MAG_W-1:0];
endmodule

// ===== hw/rtl/ohc_queue.sv =====
// Short queue between the input stage and the arithmetic pipeline.
// Depends on ohc_pkg.
module ohc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ohc_pkg::arc_item_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output ohc_pkg::arc_item_t head
);
	import ohc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	arc_item_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_QW-1:0] cnt_q;

	assign full  = cnt_q == CNT_QW'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end
endmodule

// ===== hw/rtl/ohc_arc_div.sv =====
// Bit-serial pipelined division of both arc products by pulses per revolution,
// then the signed arc difference. Depends on ohc_pkg.
module ohc_arc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       vld_in,
	input  ohc_pkg::arc_item_t         item,
	input  logic [ohc_pkg::PPR_W-1:0]  dsor,
	output logic                       vld_out,
	output logic signed [ohc_pkg::DIFF_W-1:0] diff
);
	import ohc_pkg::*;

	logic [MAG_W:0]   vld_s;
	logic [MAG_W-1:0] wl_s [MAG_W+1];
	logic [MAG_W-1:0] wr_s [MAG_W+1];
	logic [PPR_W-1:0] rl_s [MAG_W+1];
	logic [PPR_W-1:0] rr_s [MAG_W+1];
	logic             nl_s [MAG_W+1];
	logic             nr_s [MAG_W+1];
	logic             diff_vld_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DIFF_W-1:0] arc_l, arc_r;

	assign vld_s[0] = vld_in;
	assign wl_s[0]  = item.mag_l;
	assign wr_s[0]  = item.mag_r;
	assign rl_s[0]  = '0;
	assign rr_s[0]  = '0;
	assign nl_s[0]  = item.neg_l;
	assign nr_s[0]  = item.neg_r;

	for (genvar k = 0; k < MAG_W; k++) begin : g_stage
		logic [PPR_W:0] tl, tr;
		logic           gel, ger;

		assign tl  = {rl_s[k], wl_s[k][MAG_W-1]};
		assign tr  = {rr_s[k], wr_s[k][MAG_W-1]};
		assign gel = tl >= {1'b0, dsor};
		assign ger = tr >= {1'b0, dsor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rl_s[k+1] <= gel ? PPR_W'(tl - {1'b0, dsor}) : PPR_W'(tl);
				rr_s[k+1] <= ger ? PPR_W'(tr - {1'b0, dsor}) : PPR_W'(tr);
				wl_s[k+1] <= {wl_s[k][MAG_W-2:0], gel};
				wr_s[k+1] <= {wr_s[k][MAG_W-2:0], ger};
				nl_s[k+1] <= nl_s[k];
				nr_s[k+1] <= nr_s[k];
			end
		end
	end

	assign arc_l = nl_s[MAG_W] ? -signed'({2'b00, wl_s[MAG_W]}) : signed'({2'b00, wl_s[MAG_W]});
	assign arc_r = nr_s[MAG_W] ? -signed'({2'b00, wr_s[MAG_W]}) : signed'({2'b00, wr_s[MAG_W]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_vld_q <= 1'b0;
		end else if (adv) begin
			diff_vld_q <= vld_s[MAG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_q <= arc_l - arc_r;
		end
	end

	assign vld_out = diff_vld_q;
	assign diff    = diff_q;
endmodule

// ===== hw/rtl/ohc_angle.sv =====
// Heading reduction: difference modulo 2*pi*base, scaled by 2^28 modulo the same,
// divided by base, folded into +-pi/2. Depends on ohc_pkg.
module ohc_angle (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              vld_in,
	input  logic signed [ohc_pkg::DIFF_W-1:0] diff,
	input  logic [ohc_pkg::MODV_W-1:0]        modv,
	input  logic [ohc_pkg::BASE_W-1:0]        base,
	output logic                              vld_out,
	output logic signed [ohc_pkg::VEC_W-1:0]  theta,
	output logic                              neg
);
	import ohc_pkg::*;

	localparam int DBL_N = 28;

	// magnitude of the difference
	logic              m_vld_s1;
	logic [DMAG_W-1:0] m_mag_s1;
	logic              m_neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_s1 <= 1'b0;
		end else if (adv) begin
			m_vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_neg_s1 <= diff[DIFF_W-1];
			m_mag_s1 <= diff[DIFF_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
		end
	end

	// remainder of the magnitude by modv
	logic [DMAG_W:0]   md_vld_s;
	logic [DMAG_W-1:0] md_w_s [DMAG_W+1];
	logic [MODV_W-1:0] md_r_s [DMAG_W+1];
	logic              md_n_s [DMAG_W+1];

	assign md_vld_s[0] = m_vld_s1;
	assign md_w_s[0]   = m_mag_s1;
	assign md_r_s[0]   = '0;
	assign md_n_s[0]   = m_neg_s1;

	for (genvar k = 0; k < DMAG_W; k++) begin : g_mod
		logic [MODV_W:0] t;
		logic            ge;

		assign t  = {md_r_s[k], md_w_s[k][DMAG_W-1]};
		assign ge = t >= {1'b0, modv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				md_vld_s[k+1] <= md_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				md_r_s[k+1] <= ge ? MODV_W'(t - {1'b0, modv}) : MODV_W'(t);
				md_w_s[k+1] <= {md_w_s[k][DMAG_W-2:0], 1'b0};
				md_n_s[k+1] <= md_n_s[k];
			end
		end
	end

	// wrap a negative remainder into [0, modv)
	logic              fx_vld_s2;
	logic [MODV_W-1:0] fx_r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_vld_s2 <= 1'b0;
		end else if (adv) begin
			fx_vld_s2 <= md_vld_s[DMAG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_r_s2 <= (md_n_s[DMAG_W] && md_r_s[DMAG_W] != '0) ?
				modv - md_r_s[DMAG_W] : md_r_s[DMAG_W];
		end
	end

	// scale by 2^28 modulo modv
	logic [DBL_N:0]    db_vld_s;
	logic [MODV_W-1:0] db_r_s [DBL_N+1];

	assign db_vld_s[0] = fx_vld_s2;
	assign db_r_s[0]   = fx_r_s2;

	for (genvar k = 0; k < DBL_N; k++) begin : g_dbl
		logic [MODV_W:0] t;

		assign t = {db_r_s[k], 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				db_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				db_vld_s[k+1] <= db_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				db_r_s[k+1] <= (t >= {1'b0, modv}) ? MODV_W'(t - {1'b0, modv}) : MODV_W'(t);
			end
		end
	end

	// divide by base: quotient fits in THETA_W bits
	logic [THETA_W:0]   dv_vld_s;
	logic [THETA_W-1:0] dv_w_s [THETA_W+1];
	logic [BASE_W-1:0]  dv_r_s [THETA_W+1];

	assign dv_vld_s[0] = db_vld_s[DBL_N];
	assign dv_w_s[0]   = db_r_s[DBL_N][THETA_W-1:0];
	assign dv_r_s[0]   = db_r_s[DBL_N][MODV_W-1:THETA_W];

	for (genvar k = 0; k < THETA_W; k++) begin : g_div
		logic [BASE_W:0] t;
		logic            ge;

		assign t  = {dv_r_s[k], dv_w_s[k][THETA_W-1]};
		assign ge = t >= {1'b0, base};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_r_s[k+1] <= ge ? BASE_W'(t - {1'b0, base}) : BASE_W'(t);
				dv_w_s[k+1] <= {dv_w_s[k][THETA_W-2:0], ge};
			end
		end
	end

	// fold into +-pi/2
	logic signed [VEC_W-1:0] th0, th1, th2;
	logic                    fold;
	logic                    qd_vld_s3;
	logic signed [VEC_W-1:0] qd_th_s3;
	logic                    qd_neg_s3;

	always_comb begin
		th0 = signed'({1'b0, dv_w_s[THETA_W]});
		th1 = (th0 > signed'({1'b0, Q28_PI})) ? th0 - signed'({1'b0, Q28_TWO_PI}) : th0;
		fold = 1'b0;
		th2 = th1;
		if (th1 > signed'({1'b0, Q28_HALF_PI})) begin
			th2  = th1 - signed'({1'b0, Q28_PI});
			fold = 1'b1;
		end else if (th1 < -signed'({1'b0, Q28_HALF_PI})) begin
			th2  = th1 + signed'({1'b0, Q28_PI});
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_vld_s3 <= 1'b0;
		end else if (adv) begin
			qd_vld_s3 <= dv_vld_s[THETA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qd_th_s3  <= th2;
			qd_neg_s3 <= fold;
		end
	end

	assign vld_out = qd_vld_s3;
	assign theta   = qd_th_s3;
	assign neg     = qd_neg_s3;
endmodule

// ===== hw/rtl/ohc_cordic.sv =====
// Pipelined rotation CORDIC, one iteration a stage, with fold sign and scaling to int16.
// Depends on ohc_pkg.
module ohc_cordic #(
	parameter int CORDIC_STEPS = ohc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             vld_in,
	input  logic signed [ohc_pkg::VEC_W-1:0] theta,
	input  logic                             neg,
	output logic                             vld_out,
	output logic [15:0]                      x_word,
	output logic [15:0]                      y_word
);
	import ohc_pkg::*;

	logic [CORDIC_STEPS:0]   vld_s;
	logic signed [VEC_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [VEC_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [VEC_W-1:0] z_s [CORDIC_STEPS+1];
	logic                    n_s [CORDIC_STEPS+1];

	assign vld_s[0] = vld_in;
	assign x_s[0]   = CORDIC_START;
	assign y_s[0]   = '0;
	assign z_s[0]   = theta;
	assign n_s[0]   = neg;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		logic signed [VEC_W-1:0] xs, ys, at;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = atan_q28(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + at;
				end
				n_s[i+1] <= n_s[i];
			end
		end
	end

	logic signed [VEC_W-1:0] xf, yf, xv;
	logic [VEC_W-1:0]        xm, ym;
	logic [VEC_W-1:0]        xq, yq;

	always_comb begin
		xf = n_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
		yf = n_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		xv = -xf;
		xm = xv[VEC_W-1] ? VEC_W'(-xv) : VEC_W'(xv);
		ym = yf[VEC_W-1] ? VEC_W'(-yf) : VEC_W'(yf);
		xq = xv[VEC_W-1] ? -(xm >> 21) : (xm >> 21);
		yq = yf[VEC_W-1] ? -(ym >> 21) : (ym >> 21);
	end

	assign vld_out = vld_s[CORDIC_STEPS];
	assign x_word  = xq[15:0];
	assign y_word  = yq[15:0];
endmodule

// ===== hw/rtl/odometry_heading_to_compass_regs_core.sv =====
// Top level of the odometry heading block: registers, input stage, queue, pipeline, output.
// Depends on ohc_pkg, ohc_front, ohc_queue, ohc_arc_div, ohc_angle, ohc_cordic.
//
//  channel  | handshake             | payload
//  counts   | counts_valid/_stall   | left_count, right_count
//  regs     | regs_valid/_stall     | x_msb x_lsb z_msb z_lsb y_msb y_lsb
//  config   | wr_en                 | wr_index, wr_data
//
// One count pair a cycle sustained while regs is not stalled; the dividers take one
// restoring step per stage.
// Reset clears valid bits, queue pointers and registers to 1; no clearing pass.
// A stall on regs freezes the whole pipeline; the queue keeps taking inputs until full.
module odometry_heading_to_compass_regs_core #(
	parameter int CORDIC_STEPS = ohc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       counts_valid,
	output logic                       counts_stall,
	input  ohc_pkg::counts_t           counts,
	output logic                       regs_valid,
	input  logic                       regs_stall,
	output ohc_pkg::regs_t             regs,
	input  logic                       wr_en,
	input  logic [ohc_pkg::IDX_W-1:0]  wr_index,
	input  logic [ohc_pkg::CIRC_W-1:0] wr_data
);
	import ohc_pkg::*;

	logic [CIRC_W-1:0] circ_q;
	logic [PPR_W-1:0]  ppr_q;
	logic [BASE_W-1:0] base_q;
	logic [MODV_W-1:0] modv_q;
	logic [PPR_W-1:0]  ppr_eff;
	logic [BASE_W-1:0] base_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q <= CIRC_W'(1);
			ppr_q  <= PPR_W'(1);
			base_q <= BASE_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_CIRC: circ_q <= wr_data;
				REG_PPR:  ppr_q  <= wr_data[PPR_W-1:0];
				REG_BASE: base_q <= wr_data[BASE_W-1:0];
				default:  ;
			endcase
		end
	end

	assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
	assign base_eff = (base_q == '0) ? BASE_W'(1) : base_q;

	always_ff @(posedge clk) begin
		modv_q <= MODV_W'({{BASE_W{1'b0}}, Q28_TWO_PI} * {31'd0, base_eff});
	end

	logic      adv;
	logic      regs_valid_q;
	regs_t     regs_q;
	logic      full, empty, push, pop;
	arc_item_t push_data, head;
	logic      dv_vld, an_vld, an_neg, co_vld;
	logic signed [DIFF_W-1:0] diff;
	logic signed [VEC_W-1:0]  theta;
	logic [15:0] x_word, y_word;

	assign adv = !(regs_valid_q && regs_stall);
	assign pop = adv && !empty;

	ohc_front u_front (
		.clk, .arst_n, .counts_valid, .counts_stall, .counts,
		.circ(circ_q), .full, .push, .push_data
	);

	ohc_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .full, .empty, .head
	);

	ohc_arc_div u_arc (
		.clk, .arst_n, .adv, .vld_in(pop), .item(head), .dsor(ppr_eff),
		.vld_out(dv_vld), .diff
	);

	ohc_angle u_angle (
		.clk, .arst_n, .adv, .vld_in(dv_vld), .diff, .modv(modv_q), .base(base_eff),
		.vld_out(an_vld), .theta, .neg(an_neg)
	);

	ohc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .adv, .vld_in(an_vld), .theta, .neg(an_neg),
		.vld_out(co_vld), .x_word, .y_word
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_valid_q <= 1'b0;
		end else if (adv) begin
			regs_valid_q <= co_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			regs_q.x_msb <= x_word[15:8];
			regs_q.x_lsb <= x_word[7:0];
			regs_q.z_msb <= 8'h00;
			regs_q.z_lsb <= 8'h00;
			regs_q.y_msb <= y_word[15:8];
			regs_q.y_lsb <= y_word[7:0];
		end
	end

	assign regs_valid = regs_valid_q;
	assign regs       = regs_q;
endmodule

// ===== hw/rtl/ohc_checker.sv =====
// Port-level checks of the odometry heading block, bound to the top level.
// Depends on ohc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ohc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       counts_valid,
	input logic                       counts_stall,
	input ohc_pkg::counts_t           counts,
	input logic                       regs_valid,
	input logic                       regs_stall,
	input ohc_pkg::regs_t             regs,
	input logic                       wr_en,
	input logic [ohc_pkg::IDX_W-1:0]  wr_index,
	input logic [ohc_pkg::CIRC_W-1:0] wr_data
);
	import ohc_pkg::*;

	logic signed [15:0] xw, yw;

	assign xw = {regs.x_msb, regs.x_lsb};
	assign yw = {regs.y_msb, regs.y_lsb};

	`OHC_ASSERT_CLK(a_out_hold, clk, arst_n, regs_valid && regs_stall |=> regs_valid && $stable(regs))
	`OHC_ASSERT_IMPLY(a_z_zero, clk, arst_n, regs_valid, regs.z_msb == 8'h00 && regs.z_lsb == 8'h00)
	`OHC_ASSERT_IMPLY(a_x_range, clk, arst_n, regs_valid, xw <= 16'sd40 && xw >= -16'sd40)
	`OHC_ASSERT_IMPLY(a_y_range, clk, arst_n, regs_valid, yw <= 16'sd40 && yw >= -16'sd40)
endmodule

bind odometry_heading_to_compass_regs_core ohc_checker u_ohc_checker (.*);

// ===== test/ohc_regs_checker.sv =====
// Checker for the odometry heading block: watches counts, regs and the config write port.
// Predicts each regs transfer from a count pair transfer. Depends on ohc_pkg.
module ohc_regs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       counts_valid,
	input  logic                       counts_stall,
	input  ohc_pkg::counts_t           counts,
	input  logic                       regs_valid,
	input  logic                       regs_stall,
	input  ohc_pkg::regs_t             regs,
	input  logic                       wr_en,
	input  logic [ohc_pkg::IDX_W-1:0]  wr_index,
	input  logic [ohc_pkg::CIRC_W-1:0] wr_data,
	output int                         errors,
	output int                         pending
);
	import ohc_pkg::*;

	localparam longint TWO_PI_Q28  = 64'sd1686629713;
	localparam longint PI_Q28      = 64'sd843314857;
	localparam longint HALF_PI_Q28 = 64'sd421657428;
	localparam longint VEC_START   = 64'sd39796928;
	localparam int     STEPS       = 16;

	localparam longint ARCTAN [0:10] = '{
		64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290, 64'sd16755422,
		64'sd8385879, 64'sd4193963, 64'sd2097109, 64'sd1048571, 64'sd524287, 64'sd262144
	};

	logic [23:0] circ_um;
	logic [15:0] ppr;
	logic [23:0] base_um;
	regs_t       expected_regs [$];

	function automatic longint arctan_q28(input int i);
		if (i < 11) return ARCTAN[i];
		return 64'sd1 <<< (28 - i);
	endfunction

	function automatic longint div_2p21(input longint v);
		if (v >= 0) return v >>> 21;
		return -((-v) >>> 21);
	endfunction

	function automatic regs_t heading_regs(input counts_t c);
		longint p, b, cu, arc_l, arc_r, diff, modv, r, theta, x, y, z, xs, ys;
		logic neg;
		logic [15:0] xo, yo;
		regs_t o;
		p = (ppr == 0) ? 64'sd1 : longint'({48'd0, ppr});
		b = (base_um == 0) ? 64'sd1 : longint'({40'd0, base_um});
		cu = longint'({40'd0, circ_um});
		arc_l = longint'(c.left_count) * cu / p;
		arc_r = longint'(c.right_count) * cu / p;
		diff = arc_l - arc_r;
		modv = TWO_PI_Q28 * b;
		r = diff % modv;
		if (r < 0) r = r + modv;
		for (int i = 0; i < 28; i++) begin
			r = r * 2;
			if (r >= modv) r = r - modv;
		end
		theta = r / b;
		neg = 1'b0;
		if (theta > PI_Q28) theta = theta - TWO_PI_Q28;
		if (theta > HALF_PI_Q28) begin
			theta = theta - PI_Q28;
			neg = 1'b1;
		end else if (theta < -HALF_PI_Q28) begin
			theta = theta + PI_Q28;
			neg = 1'b1;
		end
		x = VEC_START;
		y = 0;
		z = theta;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q28(i);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q28(i);
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		xo = 16'(div_2p21(-x));
		yo = 16'(div_2p21(y));
		o.x_msb = xo[15:8];
		o.x_lsb = xo[7:0];
		o.z_msb = 8'd0;
		o.z_lsb = 8'd0;
		o.y_msb = yo[15:8];
		o.y_lsb = yo[7:0];
		return o;
	endfunction

	task automatic report(input string msg);
		$display("mismatch %s", msg);
		errors++;
	endtask

	task automatic check_byte(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) report($sformatf("%s: got %02h want %02h", what, got, want));
	endtask

	initial begin
		errors = 0;
		pending = 0;
		circ_um = 24'd1;
		ppr = 16'd1;
		base_um = 24'd1;
	end

	always @(posedge clk) begin
		regs_t w;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_CIRC: circ_um = wr_data;
					REG_PPR:  ppr = wr_data[15:0];
					REG_BASE: base_um = wr_data;
					default: ;
				endcase
			end
			if (counts_valid && !counts_stall)
				expected_regs.push_back(heading_regs(counts));
			if (regs_valid && !regs_stall) begin
				if (expected_regs.size() == 0) begin
					report($sformatf("unexpected regs transfer %012h", regs));
				end else begin
					w = expected_regs.pop_front();
					check_byte("x_msb", regs.x_msb, w.x_msb);
					check_byte("x_lsb", regs.x_lsb, w.x_lsb);
					check_byte("z_msb", regs.z_msb, w.z_msb);
					check_byte("z_lsb", regs.z_lsb, w.z_lsb);
					check_byte("y_msb", regs.y_msb, w.y_msb);
					check_byte("y_lsb", regs.y_lsb, w.y_lsb);
				end
			end
			pending = expected_regs.size();
		end
	end
endmodule

// ===== test/tb_odometry_heading_to_compass_regs_core.sv =====
// Testbench top for odometry_heading_to_compass_regs_core: clock, reset, stimulus, verdict.
// Depends on ohc_pkg, the block and ohc_regs_checker.
module tb_odometry_heading_to_compass_regs_core;
	import ohc_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 290;

	logic        clk;
	logic        arst_n;
	logic        counts_valid;
	logic        counts_stall;
	counts_t     counts;
	logic        regs_valid;
	logic        regs_stall;
	regs_t       regs;
	logic        wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [CIRC_W-1:0] wr_data;
	int          errors;
	int          pending;
	logic        burst;

	odometry_heading_to_compass_regs_core dut (
		.clk(clk), .arst_n(arst_n),
		.counts_valid(counts_valid), .counts_stall(counts_stall), .counts(counts),
		.regs_valid(regs_valid), .regs_stall(regs_stall), .regs(regs),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	ohc_regs_checker chk (
		.clk(clk), .arst_n(arst_n),
		.counts_valid(counts_valid), .counts_stall(counts_stall), .counts(counts),
		.regs_valid(regs_valid), .regs_stall(regs_stall), .regs(regs),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			counts_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		counts_valid <= 1'b1;
		counts.left_count <= l;
		counts.right_count <= r;
		do @(posedge clk); while (counts_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CIRC_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		counts_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_count();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 4000) - 2000;
			2: return $urandom >> $urandom_range(0, 31);
			default: return -($urandom >> $urandom_range(0, 31));
		endcase
	endfunction

	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
			send_counts(rand_count(), rand_count());
		end
		burst = 1'b0;
	endtask

	initial begin
		int s;
		s = 0;
		while (1) begin
			@(negedge clk);
			if (arst_n) break;
		end
		forever begin
			s = burst ? 0 : $urandom_range(0, 10);
			if (s > 0) begin
				regs_stall <= 1'b1;
				repeat (s) @(negedge clk);
			end
			regs_stall <= 1'b0;
			do @(posedge clk); while (!regs_valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		counts_valid = 1'b0;
		counts = '0;
		regs_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_CIRC;
		wr_data = '0;
		burst = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_counts(32'd0, 32'd0);
		send_counts(32'h7fffffff, 32'h80000000);
		send_counts(32'h80000000, 32'h7fffffff);
		send_counts(32'h7fffffff, 32'h7fffffff);
		send_counts(32'h80000000, 32'h80000000);
		send_counts(32'hffffffff, 32'd0);
		send_counts(32'd1, 32'd0);
		send_counts(32'd2, 32'd0);
		send_counts(32'd3, 32'd0);
		send_counts(32'd0, 32'd3);
		send_counts(32'd6, 32'd0);
		send_counts(32'd0, 32'd1);
		random_items(PHASE_ITEMS);
		drain();

		write_reg(REG_CIRC, 24'hffffff);
		write_reg(REG_PPR, 24'h00ffff);
		write_reg(REG_BASE, 24'hffffff);
		write_reg(REG_UNUSED, 24'h000005);
		send_counts(32'h7fffffff, 32'h80000000);
		send_counts(32'h80000000, 32'h7fffffff);
		random_items(PHASE_ITEMS);
		drain();

		write_reg(REG_CIRC, 24'd0);
		write_reg(REG_PPR, 24'd0);
		write_reg(REG_BASE, 24'd0);
		send_counts(32'h7fffffff, 32'h80000000);
		random_items(40);
		drain();
		write_reg(REG_CIRC, 24'hffffff);
		send_counts(32'h7fffffff, 32'h80000000);
		send_counts(32'h00000001, 32'hffffffff);
		random_items(PHASE_ITEMS - 40);
		drain();

		write_reg(REG_CIRC, 24'd204203);
		write_reg(REG_PPR, 24'd1024);
		write_reg(REG_BASE, 24'd150000);
		random_items(PHASE_ITEMS);
		drain();

		for (int k = 0; k < 3; k++) begin
			write_reg(REG_CIRC, CIRC_W'($urandom));
			write_reg(REG_PPR, CIRC_W'($urandom_range(1, 65535)));
			write_reg(REG_BASE, CIRC_W'($urandom));
			random_items(PHASE_ITEMS / 3);
			drain();
		end

		repeat (250) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== odometry_heading_to_compass_regs_core.f =====
+incdir+hw/rtl
hw/rtl/ohc_pkg.sv
hw/rtl/ohc_front.sv
hw/rtl/ohc_queue.sv
hw/rtl/ohc_arc_div.sv
hw/rtl/ohc_angle.sv
hw/rtl/ohc_cordic.sv
hw/rtl/odometry_heading_to_compass_regs_core.sv
hw/rtl/ohc_checker.sv
test/ohc_regs_checker.sv
test/tb_odometry_heading_to_compass_regs_core.sv
